[hdl/u8v_pkg.sv]
// Shared types and constants for the UTF-8 buffer validator.
package u8v_pkg;

  localparam int unsigned MAX_BYTES   = 16777216;
  localparam int unsigned CNT_W       = $clog2(MAX_BYTES + 2);
  localparam int unsigned LEN_W       = 25;
  localparam int unsigned POINT_W     = 21;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BOM_0 = 8'hEF;
  localparam logic [7:0] BOM_1 = 8'hBB;
  localparam logic [7:0] BOM_2 = 8'hBF;

  localparam logic [7:0] LEAD_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD_MAX  = 8'hF4;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [POINT_W-1:0] SURR_LO = POINT_W'(32'hD800);
  localparam logic [POINT_W-1:0] SURR_HI = POINT_W'(32'hDFFF);

  typedef logic [2:0] cls_t;
  localparam cls_t CLS_ASCII = 3'd0;
  localparam cls_t CLS_ZERO  = 3'd1;
  localparam cls_t CLS_CONT  = 3'd2;
  localparam cls_t CLS_BAD   = 3'd3;
  localparam cls_t CLS_LEAD2 = 3'd4;
  localparam cls_t CLS_LEAD3 = 3'd5;
  localparam cls_t CLS_LEAD4 = 3'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
  } item_t;

endpackage

[hdl/u8v_front.sv]
// Front end: takes input transactions and classifies each byte.
module u8v_front
  import u8v_pkg::*;
(
  input  logic       in_valid,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output item_t      item
);

  cls_t cls;

  always_comb begin
    if (data_byte == 8'h00) begin
      cls = CLS_ZERO;
    end else if (data_byte[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if ((data_byte & CONT_MASK) == CONT_TAG) begin
      cls = CLS_CONT;
    end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
      cls = CLS_BAD;
    end else if (data_byte < LEAD3_MIN) begin
      cls = CLS_LEAD2;
    end else if (data_byte < LEAD4_MIN) begin
      cls = CLS_LEAD3;
    end else begin
      cls = CLS_LEAD4;
    end
  end

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign item.data = data_byte;
  assign item.last = final_byte;
  assign item.cls  = cls;

endmodule

[hdl/u8v_queue.sv]
// Short first-in first-out queue between front end and back end.
module u8v_queue
  import u8v_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t head
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

endmodule

[hdl/u8v_back.sv]
// Back end: decode state, counters and the registered result stage.
module u8v_back
  import u8v_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  item_t            head,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             is_valid,
  output logic [LEN_W-1:0] text_length,
  output logic             mark_skipped
);

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BYTES);

  logic [1:0]         pending_count, pend_next;
  logic [POINT_W-1:0] partial_point, point_next;
  logic               error_seen, err_next;
  logic [CNT_W-1:0]   byte_count, cnt_next;
  logic               mark_match, mark_next;
  logic [POINT_W-1:0] point_shift;
  logic               skip;
  logic               ok;
  logic [CNT_W-1:0]   len;

  assign pop = !q_empty && (!head.last || !out_valid || !out_stall);
  assign point_shift = {partial_point[POINT_W-7:0], head.data[5:0]};

  always_comb begin
    cnt_next   = byte_count;
    mark_next  = mark_match;
    err_next   = error_seen;
    pend_next  = pending_count;
    point_next = partial_point;
    if (byte_count == CNT_W'(0) && head.data != BOM_0) mark_next = 1'b0;
    if (byte_count == CNT_W'(1) && head.data != BOM_1) mark_next = 1'b0;
    if (byte_count == CNT_W'(2) && head.data != BOM_2) mark_next = 1'b0;
    if (!error_seen) begin
      if (pending_count != 2'd0) begin
        if (head.cls != CLS_CONT) begin
          err_next   = 1'b1;
          pend_next  = 2'd0;
          point_next = '0;
        end else begin
          pend_next = pending_count - 2'd1;
          if (pending_count == 2'd1) begin
            if (point_shift >= SURR_LO && point_shift <= SURR_HI) err_next = 1'b1;
            point_next = '0;
          end else begin
            point_next = point_shift;
          end
        end
      end else begin
        case (head.cls)
          CLS_ZERO, CLS_CONT, CLS_BAD: begin
            err_next = 1'b1;
          end
          CLS_LEAD2: begin
            point_next = POINT_W'(head.data[4:0]);
            pend_next  = 2'd1;
          end
          CLS_LEAD3: begin
            point_next = POINT_W'(head.data[3:0]);
            pend_next  = 2'd2;
          end
          CLS_LEAD4: begin
            point_next = POINT_W'(head.data[2:0]);
            pend_next  = 2'd3;
          end
          default: begin
          end
        endcase
      end
    end
    if (byte_count != CNT_LIMIT) cnt_next = byte_count + CNT_W'(1);
  end

  assign skip = mark_next && cnt_next >= CNT_W'(3);
  assign ok   = !err_next && pend_next == 2'd0 && cnt_next <= CNT_MAX;
  assign len  = ok ? (skip ? cnt_next - CNT_W'(3) : cnt_next) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      partial_point <= '0;
      error_seen    <= 1'b0;
      byte_count    <= '0;
      mark_match    <= 1'b1;
    end else if (pop) begin
      if (head.last) begin
        pending_count <= 2'd0;
        partial_point <= '0;
        error_seen    <= 1'b0;
        byte_count    <= '0;
        mark_match    <= 1'b1;
      end else begin
        pending_count <= pend_next;
        partial_point <= point_next;
        error_seen    <= err_next;
        byte_count    <= cnt_next;
        mark_match    <= mark_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      is_valid     <= ok;
      text_length  <= LEN_W'(len);
      mark_skipped <= skip;
    end
  end

  a_idle_point: assert property (@(posedge clk) disable iff (rst)
    pending_count == 2'd0 |-> partial_point == '0)
    else $error("partial code point left over outside a sequence");

  a_err_no_pend: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> pending_count == 2'd0)
    else $error("sequence still open after an error");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_LIMIT)
    else $error("byte count beyond saturation");

  a_len_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_valid |-> text_length == '0)
    else $error("length reported on an invalid buffer");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(text_length))
    else $error("stalled result lost");

endmodule

[hdl/utf8_buffer_validator.sv]
// Top level of the UTF-8 buffer validator.
// Input channel: one byte per transaction on data_byte, with final_byte
// high on the last byte of a buffer; the next byte opens a new buffer.
// Output channel: one transaction per buffer, carrying is_valid,
// text_length (bytes after a leading EF BB BF mark, 0 when invalid) and
// mark_skipped.
// Both channels transfer when valid is high and stall is low.
// Throughput is one byte per clock unless out_stall holds a result: the
// back end updates the decode state for one byte each cycle it pops. A
// final byte is written into the queue, then popped into the result
// register after any bytes queued ahead of it.
// A four-entry queue lies between the byte classifier and the decoder;
// in_stall rises only when that queue is full, which happens when a final
// byte waits behind a result held by out_stall and further bytes arrive.
// Reset empties the queue, drops any pending result and returns the
// decoder to the start-of-buffer state.
module utf8_buffer_validator
  import u8v_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_valid,
  output logic [LEN_W-1:0] text_length,
  output logic             mark_skipped
);

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t head;

  u8v_front u_front (
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .item       (push_item)
  );

  u8v_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  u8v_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .is_valid     (is_valid),
    .text_length  (text_length),
    .mark_skipped (mark_skipped)
  );

endmodule
